@@ sv/cee_pkg.sv @@
// Shared types and constants for the C string escape encoder.
// Used by every module of the block; depends on nothing else.
package cee_pkg;

  // Configuration port geometry.
  localparam int unsigned NumMaskRegs = 4;
  localparam int unsigned MaskWidth   = 64;
  localparam int unsigned RegIdxWidth = $clog2(NumMaskRegs);

  // Depth of the queue between the front and the back part.
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  // Character codes.
  localparam logic [7:0] ChrBackslash = 8'h5C;
  localparam logic [7:0] ChrZero      = 8'h30;
  localparam logic [7:0] ChrPrintLo   = 8'h20;
  localparam logic [7:0] ChrPrintHi   = 8'h7E;
  localparam logic [7:0] ChrNewline   = 8'h0A;
  localparam logic [7:0] ChrTab       = 8'h09;
  localparam logic [7:0] ChrBackspace = 8'h08;
  localparam logic [7:0] ChrReturn    = 8'h0D;
  localparam logic [7:0] ChrFormFeed  = 8'h0C;
  localparam logic [7:0] ChrVertTab   = 8'h0B;
  localparam logic [7:0] LetN         = 8'h6E;
  localparam logic [7:0] LetT         = 8'h74;
  localparam logic [7:0] LetB         = 8'h62;
  localparam logic [7:0] LetR         = 8'h72;
  localparam logic [7:0] LetF         = 8'h66;
  localparam logic [7:0] LetV         = 8'h76;

  // How one input byte is expanded.
  typedef enum logic [1:0] {
    KindPass   = 2'd0,  // one beat: the byte itself
    KindDouble = 2'd1,  // two backslashes
    KindLetter = 2'd2,  // backslash and a letter
    KindOctal  = 2'd3   // backslash and three octal digits
  } kind_e;

  // One classified item as it waits in the queue. For a letter escape the
  // symbol is the letter, otherwise it is the input byte.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] sym;
  } item_t;

endpackage

@@ sv/cee_classify.sv @@
// Front part of the escape encoder: holds the except mask registers and
// classifies each accepted input byte. Depends on cee_pkg.
module cee_classify
  import cee_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [RegIdxWidth-1:0] cfg_idx_i,
  input  logic [MaskWidth-1:0]   cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             in_byte_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output item_t                  q_item_o
);

  logic [MaskWidth-1:0] mask_q [NumMaskRegs];
  logic                 excepted;
  logic                 printable;
  logic [7:0]           letter;

  // Except mask registers, written through the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMaskRegs; i++) begin
        mask_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      mask_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign excepted  = mask_q[in_byte_i[7:6]][in_byte_i[5:0]];
  assign printable = (in_byte_i >= ChrPrintLo) && (in_byte_i <= ChrPrintHi);

  // Letter for the named control characters; zero means none.
  always_comb begin
    unique case (in_byte_i)
      ChrNewline:   letter = LetN;
      ChrTab:       letter = LetT;
      ChrBackspace: letter = LetB;
      ChrReturn:    letter = LetR;
      ChrFormFeed:  letter = LetF;
      ChrVertTab:   letter = LetV;
      default:      letter = 8'h00;
    endcase
  end

  // Classification. The terminator and excepted bytes pass unchanged.
  always_comb begin
    q_item_o.sym = in_byte_i;
    if (in_byte_i == 8'h00 || excepted) begin
      q_item_o.kind = KindPass;
    end else if (printable) begin
      q_item_o.kind = (in_byte_i == ChrBackslash) ? KindDouble : KindPass;
    end else if (letter != 8'h00) begin
      q_item_o.kind = KindLetter;
      q_item_o.sym  = letter;
    end else begin
      q_item_o.kind = KindOctal;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

@@ sv/cee_queue.sv @@
// Short queue of classified items between the front and the back part.
// Depends on cee_pkg.
module cee_queue
  import cee_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t                slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

endmodule

@@ sv/cee_expand.sv @@
// Back part of the escape encoder: turns the item at the head of the queue
// into one to four output beats through a registered output stage.
// Depends on cee_pkg.
module cee_expand
  import cee_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  item_t      q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [1:0] beat_q, beat_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;
  logic [7:0] nxt_byte;
  logic       nxt_last;

  // The output register takes a new beat when it is empty or being drained.
  assign load = q_valid_i && (!valid_q || out_ready_i);

  // Beat generation for the head item.
  always_comb begin
    nxt_byte = ChrBackslash;
    nxt_last = 1'b0;
    case (q_item_i.kind)
      KindPass: begin
        nxt_byte = q_item_i.sym;
        nxt_last = 1'b1;
      end
      KindDouble: begin
        nxt_last = (beat_q == 2'd1);
      end
      KindLetter: begin
        if (beat_q != 2'd0) begin
          nxt_byte = q_item_i.sym;
          nxt_last = 1'b1;
        end
      end
      default: begin
        case (beat_q)
          2'd1:    nxt_byte = ChrZero + {5'd0, 1'b0, q_item_i.sym[7:6]};
          2'd2:    nxt_byte = ChrZero + {5'd0, q_item_i.sym[5:3]};
          2'd3: begin
            nxt_byte = ChrZero + {5'd0, q_item_i.sym[2:0]};
            nxt_last = 1'b1;
          end
          default: nxt_byte = ChrBackslash;
        endcase
      end
    endcase
  end

  assign q_pop_o = load && nxt_last;

  always_comb begin
    beat_d  = beat_q;
    valid_d = valid_q;
    if (load) begin
      beat_d  = nxt_last ? 2'd0 : beat_q + 2'd1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      beat_q  <= beat_d;
      valid_q <= valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= nxt_byte;
      last_q <= nxt_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

@@ sv/c_escape_encoder.sv @@
// Top level of the C string escape encoder.
// Depends on cee_pkg, cee_classify, cee_queue and cee_expand.

// Each input beat carries one byte and produces one to four output beats:
// the byte itself, a doubled backslash, a backslash and a letter, or a
// backslash and three octal digits; tlast marks the final beat of each
// input byte, and a zero byte gives a single zero. The output side moves one
// beat per cycle while m_axis_tready is high. A four-entry queue lets input
// bytes be accepted every cycle until it fills, while earlier bytes are still
// being expanded. The four 64-bit except mask registers are written through
// cfg_we_i, cfg_idx_i and cfg_data_i; the user must write them only while the
// block is idle, which the block itself does not enforce. All are clear
// after reset.
module c_escape_encoder
  import cee_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [RegIdxWidth-1:0] cfg_idx_i,
  input  logic [MaskWidth-1:0]   cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
  output logic                   m_axis_tlast    // last_of_run
);

  logic  q_push, q_full, q_pop, q_valid;
  item_t q_in, q_out;

  // Front: mask registers and classification.
  cee_classify u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  // Queue between the two parts.
  cee_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  // Back: beat expansion and output register.
  cee_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
